// File: hdl/wwd_pkg.sv
// shared types and constants for the weighted window differential
`default_nettype none
package wwd_pkg;
    localparam int unsigned LEN_W   = 7;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DIFF_W  = 32;

    typedef enum logic [1:0] {
        MODE_RIGHT = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_PLAIN = 2'd2,
        MODE_ALT   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_LEFT_LEN  = 2'd0,
        REG_RIGHT_LEN = 2'd1,
        REG_MODE      = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DIV_R,
        ST_DIV_L,
        ST_MUL,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// File: hdl/wwd_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module wwd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 129
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/wwd_div.sv
// restoring divider, one quotient bit per cycle, signed truncating result
`default_nettype none
module wwd_div #(
    parameter int unsigned SW = 23
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic signed [SW-1:0]        dividend,
    input  wire logic [wwd_pkg::LEN_W-1:0]   divisor,
    output logic                             busy,
    output logic signed [SW-1:0]             quotient
);
    localparam int unsigned W = SW;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]       q_reg, q_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               busy_reg, busy_next;
    logic [W:0]         trial;
    logic [W-1:0]       absd;

    always_comb begin
        absd     = dividend[W-1] ? W'(-dividend) : dividend;
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        trial    = {rem_reg, q_reg[W-1]} - {{(W+1-wwd_pkg::LEN_W){1'b0}}, divisor};
        if (start) begin
            q_next    = absd;
            rem_next  = '0;
            cnt_next  = CW'(W);
            neg_next  = dividend[W-1];
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift one dividend bit into the remainder per cycle
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-2:0], q_reg[W-1]};
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? W'(-q_reg) : q_reg;
endmodule
`default_nettype wire

// File: hdl/wwd_mul.sv
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module wwd_mul #(
    parameter int unsigned SW = 23
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic signed [SW:0]               a,
    input  wire logic signed [SW-1:0]             b,
    output logic                                  busy,
    output logic [wwd_pkg::DIFF_W-1:0]            product
);
    localparam int unsigned BW = SW;
    localparam int unsigned PW = wwd_pkg::DIFF_W;
    localparam int unsigned CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mc_reg, mc_next;
    logic [BW-1:0] mp_reg, mp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;

    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            acc_next  = '0;
            mc_next   = PW'(a);
            mp_next   = b;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // top bit of b carries negative weight in two's complement
            if (mp_reg[0]) begin
                acc_next = (cnt_reg == CW'(1)) ? acc_reg - mc_reg : acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[PW-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[BW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

// File: hdl/weighted_window_differential.sv
// top level: history memory, window sum scan, serial divide and multiply
//
//  channel | ports              | payload
//  input   | s_tvalid/s_tready  | s_tdata[15:0] sample
//  result  | m_tvalid/m_tready  | m_tdata[31:0] diff
//  config  | cfg_we/cfg_addr    | cfg_wdata[6:0]
//
// after reset all LEFT_MAX+RIGHT_MAX+1 history entries are cleared, one entry a
// cycle, before the first sample is taken.
// per transaction: accept, scan of the window taps, a serial division for each
// window (skipped when its window is empty), a serial multiply in the weighting
// modes, and output. one sample is worked at a time; a new one is taken while
// the last result waits in m_tdata, and a finished result holds in the output
// state until that register is free.
`default_nettype none
module weighted_window_differential #(
    parameter int unsigned LEFT_MAX    = 64,
    parameter int unsigned RIGHT_MAX   = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [wwd_pkg::DIFF_W-1:0]                 m_tdata,   // diff
    input  wire logic                                  cfg_we,
    input  wire logic [1:0]                            cfg_addr,
    input  wire logic [wwd_pkg::LEN_W-1:0]             cfg_wdata
);
    localparam int unsigned DEPTH = LEFT_MAX + RIGHT_MAX + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned LW    = wwd_pkg::LEN_W;
    // a window holds at most 2**LW-1 samples
    localparam int unsigned SW    = SAMPLE_BITS + LW;
    localparam int unsigned KW    = $clog2(DEPTH + 3);

    // configuration
    logic [LW-1:0]  left_len_reg, right_len_reg;
    wwd_pkg::mode_t mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_len_reg  <= LW'(10);
            right_len_reg <= LW'(20);
            mode_reg      <= wwd_pkg::MODE_RIGHT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                wwd_pkg::REG_LEFT_LEN:  left_len_reg  <= cfg_wdata;
                wwd_pkg::REG_RIGHT_LEN: right_len_reg <= cfg_wdata;
                wwd_pkg::REG_MODE:      mode_reg      <= wwd_pkg::mode_t'(cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    wwd_pkg::state_t state_reg, state_next;
    logic [AW-1:0]  head_reg, head_next, clr_reg, clr_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [LW-1:0]  nl_reg, nl_next, nr_reg, nr_next;
    logic signed [SW-1:0] lsum_reg, lsum_next, rsum_reg, rsum_next;
    logic signed [SW-1:0] lmean_reg, lmean_next, rmean_reg, rmean_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [wwd_pkg::DIFF_W-1:0] out_reg, out_next;
    logic           mv_reg, mv_next;

    // saturated lengths, left length forced to 1 when both are zero
    logic [LW-1:0] nl_c, nr_c;
    always_comb begin
        nl_c = (32'(left_len_reg) > LEFT_MAX) ? LW'(LEFT_MAX) : left_len_reg;
        nr_c = (32'(right_len_reg) > RIGHT_MAX) ? LW'(RIGHT_MAX) : right_len_reg;
        if (nl_c == '0 && nr_c == '0) begin
            nl_c = LW'(1);
        end
    end

    // memory
    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [SAMPLE_BITS-1:0] wdata, rdata;
    wwd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_hist (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // read address: tap k back from head, k from 0 up to nr+nl+1; the last read is unused
    logic [AW:0] back_sum;
    always_comb begin
        back_sum = {1'b0, head_reg} + (AW+1)'(DEPTH) - (AW+1)'(k_reg);
        raddr = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                             : back_sum[AW-1:0];
    end

    // data read last cycle is tap k-1
    logic [KW-1:0] kp;
    assign kp = k_reg - KW'(1);

    // divider and multiplier
    logic                 div_start, div_busy;
    logic signed [SW-1:0] div_a, quot;
    logic [LW-1:0]        div_b;
    wwd_div #(.SW(SW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(quot)
    );

    logic                 mul_start, mul_busy;
    logic signed [SW:0]   mul_a;
    logic signed [SW-1:0] mul_b;
    logic [wwd_pkg::DIFF_W-1:0] prod;
    wwd_mul #(.SW(SW)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(mul_a), .b(mul_b),
        .busy(mul_busy), .product(prod)
    );

    logic div_started_reg, div_started_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wwd_pkg::ST_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = wwd_pkg::ST_IDLE;
            wwd_pkg::ST_IDLE:  if (s_tvalid) state_next = wwd_pkg::ST_SCAN;
            wwd_pkg::ST_SCAN:
                if (32'(k_reg) == 32'(nr_reg) + 32'(nl_reg) + 1) state_next = wwd_pkg::ST_DIV_R;
            wwd_pkg::ST_DIV_R:
                if (div_started_reg && !div_busy) state_next = wwd_pkg::ST_DIV_L;
            wwd_pkg::ST_DIV_L:
                if (div_started_reg && !div_busy) begin
                    state_next = (mode_reg == wwd_pkg::MODE_RIGHT ||
                                  mode_reg == wwd_pkg::MODE_LEFT) ? wwd_pkg::ST_MUL
                                                                  : wwd_pkg::ST_OUT;
                end
            wwd_pkg::ST_MUL:   if (div_started_reg && !mul_busy) state_next = wwd_pkg::ST_OUT;
            // hold the finished result until the output register is free
            wwd_pkg::ST_OUT:   if (!mv_reg || m_tready) state_next = wwd_pkg::ST_IDLE;
            default:           state_next = wwd_pkg::ST_IDLE;
        endcase
    end

    logic signed [SW+1:0] xw, plain;
    // outputs and datapath
    always_comb begin
        we = 1'b0; waddr = head_reg; wdata = s_tdata[SAMPLE_BITS-1:0];
        head_next = head_reg; clr_next = clr_reg; k_next = k_reg;
        nl_next = nl_reg; nr_next = nr_reg;
        lsum_next = lsum_reg; rsum_next = rsum_reg;
        lmean_next = lmean_reg; rmean_next = rmean_reg;
        x_next = x_reg; out_next = out_reg; mv_next = mv_reg;
        div_start = 1'b0; div_a = rsum_reg; div_b = nr_reg;
        mul_start = 1'b0; div_started_next = div_started_reg;
        s_tready = 1'b0;
        xw = (SW+2)'(x_reg);
        mul_a = (SW+1)'(x_reg) - (SW+1)'(lmean_reg);
        mul_b = rmean_reg;
        if (mode_reg == wwd_pkg::MODE_LEFT) begin
            mul_a = (SW+1)'(x_reg) - (SW+1)'(rmean_reg);
            mul_b = lmean_reg;
        end
        if (nl_reg != '0 && nr_reg != '0) begin
            plain = xw - (((SW+2)'(lmean_reg) + (SW+2)'(rmean_reg)) >>> 1);
        end else if (nr_reg != '0) begin
            plain = xw - (SW+2)'(rmean_reg);
        end else begin
            plain = xw - (SW+2)'(lmean_reg);
        end
        if (m_tready) mv_next = 1'b0;
        unique case (state_reg)
            wwd_pkg::ST_CLEAR: begin
                we = 1'b1; waddr = clr_reg; wdata = '0;
                clr_next = clr_reg + AW'(1);
            end
            wwd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    we = 1'b1; waddr = head_next;
                    nl_next = nl_c; nr_next = nr_c;
                    lsum_next = '0; rsum_next = '0; k_next = '0;
                end
            end
            wwd_pkg::ST_SCAN: begin
                k_next = k_reg + KW'(1);
                if (k_reg != '0) begin
                    // tap kp is in rdata
                    if (32'(kp) < 32'(nr_reg))
                        rsum_next = rsum_reg + SW'(signed'(rdata));
                    else if (32'(kp) == 32'(nr_reg))
                        x_next = rdata;
                    else
                        lsum_next = lsum_reg + SW'(signed'(rdata));
                end
                div_started_next = 1'b0;
            end
            wwd_pkg::ST_DIV_R: begin
                div_a = rsum_reg; div_b = nr_reg;
                if (!div_started_reg) begin
                    div_start = (nr_reg != '0);
                    div_started_next = 1'b1;
                    rmean_next = '0;
                end else if (!div_busy) begin
                    if (nr_reg != '0) rmean_next = quot;
                    div_started_next = 1'b0;
                end
            end
            wwd_pkg::ST_DIV_L: begin
                div_a = lsum_reg; div_b = nl_reg;
                if (!div_started_reg) begin
                    div_start = (nl_reg != '0);
                    div_started_next = 1'b1;
                    lmean_next = '0;
                end else if (!div_busy) begin
                    if (nl_reg != '0) lmean_next = quot;
                    div_started_next = 1'b0;
                end
            end
            wwd_pkg::ST_MUL: begin
                if (!div_started_reg) begin
                    mul_start = 1'b1;
                    div_started_next = 1'b1;
                end
            end
            wwd_pkg::ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    out_next = (mode_reg == wwd_pkg::MODE_RIGHT ||
                                mode_reg == wwd_pkg::MODE_LEFT)
                               ? prod : wwd_pkg::DIFF_W'(plain);
                    mv_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wwd_pkg::ST_CLEAR;
            clr_reg   <= '0;
            head_reg  <= '0;
            mv_reg    <= 1'b0;
            k_reg     <= '0;
            div_started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            mv_reg    <= mv_next;
            k_reg     <= k_next;
            div_started_reg <= div_started_next;
        end
        nl_reg <= nl_next; nr_reg <= nr_next;
        lsum_reg <= lsum_next; rsum_reg <= rsum_next;
        lmean_reg <= lmean_next; rmean_reg <= rmean_next;
        x_reg <= x_next; out_reg <= out_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

    // a stalled result holds its value
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    // a result appears only from the output state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == wwd_pkg::ST_OUT) else $error("stray result");
    // divider never restarted while busy
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restart");
endmodule
`default_nettype wire

// File: verif/wwd_checker.sv
// checker for the weighted window differential: predicts diff per sample and compares
`timescale 1ns / 100ps
`default_nettype none
module wwd_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [6:0]  cfg_wdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);
    localparam int LMAX  = 64;
    localparam int RMAX  = 64;
    localparam int DEPTH = LMAX + RMAX + 1;

    logic signed [15:0] delay_line [DEPTH];
    int                 head_pos;
    logic [6:0]         left_len_q, right_len_q;
    wwd_pkg::mode_t     mode_q;
    logic [31:0]        diff_queue [$];

    function automatic logic signed [15:0] sample_back(int back);
        return delay_line[(head_pos + DEPTH - (back % DEPTH)) % DEPTH];
    endfunction

    // computes diff for the centre sample after the newest has been pushed
    function automatic logic [31:0] weighted_diff();
        int nl, nr;
        longint x, lsum, rsum, lmean, rmean, d, s;
        nl = (left_len_q > LMAX) ? LMAX : left_len_q;
        nr = (right_len_q > RMAX) ? RMAX : right_len_q;
        if (nl == 0 && nr == 0) nl = 1;
        x = sample_back(nr);
        rsum = 0;
        lsum = 0;
        lmean = 0;
        rmean = 0;
        for (int i = 0; i < nr; i++) rsum += sample_back(i);
        for (int i = 1; i <= nl; i++) lsum += sample_back(nr + i);
        if (nr > 0) rmean = rsum / nr;
        if (nl > 0) lmean = lsum / nl;
        if (mode_q == wwd_pkg::MODE_RIGHT) begin
            d = (x - lmean) * rmean;
        end else if (mode_q == wwd_pkg::MODE_LEFT) begin
            d = (x - rmean) * lmean;
        end else if (nl > 0 && nr > 0) begin
            s = lmean + rmean;
            d = x - (s >>> 1);
        end else if (nr > 0) begin
            d = x - rmean;
        end else begin
            d = x - lmean;
        end
        return d[31:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) delay_line[i] = '0;
            head_pos      = 0;
            left_len_q    <= 7'd10;
            right_len_q   <= 7'd20;
            mode_q        <= wwd_pkg::MODE_RIGHT;
            fail_count    <= 0;
            result_count  <= 0;
            pending_count <= 0;
            diff_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    wwd_pkg::REG_LEFT_LEN:  left_len_q  <= cfg_wdata;
                    wwd_pkg::REG_RIGHT_LEN: right_len_q <= cfg_wdata;
                    wwd_pkg::REG_MODE:      mode_q      <= wwd_pkg::mode_t'(cfg_wdata[1:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                // blocking update of the model line so the prediction sees the new sample
                head_pos = (head_pos + 1) % DEPTH;
                delay_line[head_pos] = s_tdata;
                diff_queue.push_back(weighted_diff());
            end
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (diff_queue.size() == 0) begin
                    $display("%0t: unexpected diff transaction, expected none, actual %h",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    if (diff_queue[0] !== m_tdata) begin
                        $display("%0t: diff mismatch, expected %h, actual %h",
                                 $time, diff_queue[0], m_tdata);
                        fail_count <= fail_count + 1;
                    end
                    void'(diff_queue.pop_front());
                end
            end
            pending_count <= diff_queue.size();
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_weighted_window_differential.sv
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_weighted_window_differential;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // sample
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // diff
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [6:0]  cfg_wdata;
    int          fail_count, pending_count, result_count;
    int          cycle_count;
    int          sample_count;
    bit          calm_stretch;

    localparam int CYCLE_LIMIT = 2000000;

    weighted_window_differential dut (.*);

    wwd_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls about 10 percent of cycles, except in the calm stretch
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm_stretch ? 1'b1 : ($urandom_range(99) >= 10);
    end

    task automatic write_reg(wwd_pkg::reg_idx_t idx, logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // drops tvalid, then waits until every expected result has come
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // tvalid stays high after the transaction so samples can follow back to back
    task automatic send_sample(logic [15:0] value);
        while (!calm_stretch && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sample_count++;
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(logic [6:0] ll, logic [6:0] rl, wwd_pkg::mode_t md, int n);
        wait_drained();
        write_reg(wwd_pkg::REG_LEFT_LEN, ll);
        write_reg(wwd_pkg::REG_RIGHT_LEN, rl);
        write_reg(wwd_pkg::REG_MODE, 7'(md));
        for (int i = 0; i < n; i++) send_sample(random_sample());
    endtask

    initial begin
        cycle_count  = 0;
        sample_count = 0;
        calm_stretch = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = wwd_pkg::REG_LEFT_LEN;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset lengths on zero history, then field extremes
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        // both lengths zero, oversize lengths, unused mode value, one-sided windows, maximum lengths
        run_phase(7'd0, 7'd0, wwd_pkg::MODE_PLAIN, 4);
        run_phase(7'd127, 7'd65, wwd_pkg::MODE_ALT, 4);
        run_phase(7'd0, 7'd3, wwd_pkg::MODE_PLAIN, 3);
        run_phase(7'd3, 7'd0, wwd_pkg::MODE_PLAIN, 3);
        run_phase(7'd64, 7'd64, wwd_pkg::MODE_LEFT, 4);

        // random phases over lengths and modes, with extremes mixed in
        for (int p = 0; p < 40; p++) begin
            logic [6:0] ll, rl;
            ll = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
            rl = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
            calm_stretch = (p >= 10 && p < 14);
            run_phase(ll, rl, wwd_pkg::mode_t'($urandom_range(3)), 27);
        end

        wait_drained();
        repeat (200) @(posedge aclk);
        $display("covered %0d samples and %0d diff results over 46 length/mode settings",
                 sample_count, result_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
